### rtl/bwrs_pkg.sv
// Package for the batched window retransmit sender.
// Beat payload types, opcode and kind codes, controller states, and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package bwrs_pkg;

  localparam int unsigned SEQ_W    = 32;
  localparam int unsigned TOTAL_W  = 24;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned BR_W     = 6;
  localparam logic [BR_W-1:0] BR_MAX = 6'd63;
  localparam int unsigned MAX_RUN  = 32;
  localparam int unsigned RUN_W    = 6;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 24'd1000000;
  localparam logic [ID_W-1:0]    CLIENT_RESET = 16'd0;

  // register index, taken from paddr[2]
  localparam logic REG_TOTAL  = 1'b0;
  localparam logic REG_CLIENT = 1'b1;

  typedef enum logic [1:0] {
    OP_SEND    = 2'd0,
    OP_ACK     = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_NEW  = 2'd1,
    KIND_RETX = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_CLOSE,
    ST_MARK,
    ST_ADV,
    ST_FIN,
    ST_RTX,
    ST_NOP
  } state_e;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [SEQ_W-1:0] ack_seq;
  } in_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [SEQ_W-1:0] seq;
    logic [ID_W-1:0]  sender_id;
    logic             last;
    logic             all_sent;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic do_send;
    logic do_close;
    logic do_mark;
    logic do_adv;
    logic do_fin;
    logic do_rtx;
    logic do_nop;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic adv_more;
    logic rtx_last;
  } dp_status_t;

endpackage

### rtl/bwrs_ctrl.sv
// Controller state machine for the batched window retransmit sender.
// Sequences one input item at a time into datapath commands; uses bwrs_pkg.
`timescale 1ns / 1ps

module bwrs_ctrl
  import bwrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_opcode_i,
  input  dp_status_t status_i,
  output logic       in_stall_o,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (in_opcode_i)
            OP_SEND:    state_d = ST_SEND;
            OP_ACK:     state_d = ST_MARK;
            OP_TIMEOUT: state_d = ST_RTX;
            default:    state_d = ST_NOP;
          endcase
        end
      end
      ST_SEND: begin
        cmd_o.do_send = 1'b1;
        state_d = ST_CLOSE;
      end
      ST_CLOSE: begin
        if (status_i.out_free) begin
          cmd_o.do_close = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_MARK: begin
        cmd_o.do_mark = 1'b1;
        state_d = ST_ADV;
      end
      ST_ADV: begin
        // slide base one slot per cycle
        if (status_i.adv_more) begin
          cmd_o.do_adv = 1'b1;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (status_i.out_free) begin
          cmd_o.do_fin = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_RTX: begin
        if (status_i.out_free) begin
          cmd_o.do_rtx = 1'b1;
          if (status_i.rtx_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_NOP: begin
        if (status_i.out_free) begin
          cmd_o.do_nop = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/bwrs_datapath.sv
// Datapath for the batched window retransmit sender: window counters,
// ack ring, batch counters and the result output register. Uses bwrs_pkg.
`timescale 1ns / 1ps

module bwrs_datapath
  import bwrs_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [TOTAL_W-1:0] total_i,
  input  logic [ID_W-1:0]    client_i,
  input  in_item_t           in_item_i,
  input  dp_cmd_t            cmd_i,
  output dp_status_t         status_o,
  output logic               out_valid_o,
  output out_item_t          out_item_o,
  input  logic               out_stall_i
);

  localparam int unsigned SW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int unsigned BSW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned CW  = (BSW > BR_W) ? BSW : BR_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW_DEPTH - 1);

  logic [SEQ_W-1:0]        base_q, base_d, next_q, next_d;
  logic [SW-1:0]           bslot_q, bslot_d, nslot_q, nslot_d;
  logic [WINDOW_DEPTH-1:0] ring_q, ring_d;
  logic [TOTAL_W-1:0]      sent_q, sent_d;
  logic [BSW-1:0]          bs_q, bs_d;
  logic [BR_W-1:0]         br_q, br_d;
  logic                    waiting_q, waiting_d;
  logic [RUN_W-1:0]        run_q, run_d;
  in_item_t                item_q, item_d;
  logic                    pend_new_q, pend_new_d;
  logic [SEQ_W-1:0]        pend_seq_q, pend_seq_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q, out_d;

  logic [SEQ_W-1:0] span, diff;
  logic [SW:0]      slot_sum;
  logic [SW-1:0]    ack_slot;
  logic [RUN_W-1:0] span_sat;
  logic             can_send, rcv_met, rtx_last, push, push_last;
  kind_e            push_kind;
  logic [SEQ_W-1:0] push_seq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= '0;
      next_q      <= '0;
      bslot_q     <= '0;
      nslot_q     <= '0;
      ring_q      <= '0;
      sent_q      <= '0;
      bs_q        <= '0;
      br_q        <= '0;
      waiting_q   <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      base_q      <= base_d;
      next_q      <= next_d;
      bslot_q     <= bslot_d;
      nslot_q     <= nslot_d;
      ring_q      <= ring_d;
      sent_q      <= sent_d;
      bs_q        <= bs_d;
      br_q        <= br_d;
      waiting_q   <= waiting_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    pend_new_q <= pend_new_d;
    pend_seq_q <= pend_seq_d;
    out_q      <= out_d;
  end

  assign span     = next_q - base_q;
  assign diff     = item_q.ack_seq - base_q;
  assign can_send = (bs_q < BSW'(WINDOW_DEPTH)) && (sent_q < total_i) &&
                    (span < SEQ_W'(WINDOW_DEPTH));
  assign rcv_met  = CW'(br_q) >= CW'(bs_q);

  // diff < span <= depth, so one conditional subtract wraps the slot
  always_comb begin
    slot_sum = {1'b0, bslot_q} + {1'b0, diff[SW-1:0]};
    if (slot_sum >= (SW + 1)'(WINDOW_DEPTH)) begin
      slot_sum = slot_sum - (SW + 1)'(WINDOW_DEPTH);
    end
    ack_slot = slot_sum[SW-1:0];
  end

  assign span_sat = (span > SEQ_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : span[RUN_W-1:0];
  assign rtx_last = (span == '0) || (RUN_W'(run_q + 1'b1) == span_sat);

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign status_o.adv_more = (base_q != next_q) && ring_q[bslot_q];
  assign status_o.rtx_last = rtx_last;

  always_comb begin
    base_d     = base_q;
    next_d     = next_q;
    bslot_d    = bslot_q;
    nslot_d    = nslot_q;
    ring_d     = ring_q;
    sent_d     = sent_q;
    bs_d       = bs_q;
    br_d       = br_q;
    waiting_d  = waiting_q;
    run_d      = run_q;
    item_d     = item_q;
    pend_new_d = pend_new_q;
    pend_seq_d = pend_seq_q;
    push       = 1'b0;
    push_kind  = KIND_NONE;
    push_seq   = '0;
    push_last  = 1'b1;

    if (cmd_i.capture) begin
      item_d = in_item_i;
      run_d  = '0;
    end

    if (cmd_i.do_send) begin
      if (!waiting_q && can_send) begin
        ring_d[nslot_q] = 1'b0;
        next_d     = next_q + 1'b1;
        nslot_d    = (nslot_q == LAST_SLOT) ? '0 : SW'(nslot_q + 1'b1);
        sent_d     = sent_q + 1'b1;
        bs_d       = bs_q + 1'b1;
        pend_new_d = 1'b1;
        pend_seq_d = next_q;
      end else begin
        pend_new_d = 1'b0;
      end
    end

    if (cmd_i.do_close) begin
      // close the batch when nothing more can go out; reopen at once if acked
      if (!waiting_q && (bs_q != '0) && !can_send) begin
        if (rcv_met) begin
          bs_d = '0;
          br_d = '0;
        end else begin
          waiting_d = 1'b1;
        end
      end
      push      = 1'b1;
      push_kind = pend_new_q ? KIND_NEW : KIND_NONE;
      push_seq  = pend_seq_q;
    end

    if (cmd_i.do_mark) begin
      if (diff < span) begin
        ring_d[ack_slot] = 1'b1;
      end
      if (br_q < BR_MAX) begin
        br_d = br_q + 1'b1;
      end
    end

    if (cmd_i.do_adv) begin
      base_d  = base_q + 1'b1;
      bslot_d = (bslot_q == LAST_SLOT) ? '0 : SW'(bslot_q + 1'b1);
    end

    if (cmd_i.do_fin) begin
      if (waiting_q && rcv_met) begin
        waiting_d = 1'b0;
        bs_d      = '0;
        br_d      = '0;
      end
      push = 1'b1;
    end

    if (cmd_i.do_rtx) begin
      push = 1'b1;
      if (span != '0) begin
        push_kind = KIND_RETX;
        push_seq  = base_q + SEQ_W'(run_q);
        push_last = rtx_last;
        run_d     = RUN_W'(run_q + 1'b1);
      end
    end

    if (cmd_i.do_nop) begin
      push = 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (push) begin
      out_valid_d        = 1'b1;
      out_d.kind         = push_kind;
      out_d.seq          = (push_kind == KIND_NONE) ? '0 : push_seq;
      out_d.sender_id    = (push_kind == KIND_NONE) ? '0 : client_i;
      out_d.last         = push_last;
      out_d.all_sent     = (sent_q >= total_i) && !waiting_d;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### rtl/batched_window_retransmit_sender.sv
// Top level of the batched window retransmit sender: APB-style register
// port, controller and datapath. Uses bwrs_pkg, bwrs_ctrl, bwrs_datapath.
//
// Usage:
//   Input beats (in_valid_i/in_stall_o, in_item_i) carry an opcode: send
//   opportunity, acknowledgement or retransmit timeout. Each beat yields one
//   or more result beats (out_valid_o/out_stall_i, out_item_o); the final
//   result of a beat has last set.
//   Items are handled one at a time; in_stall_o is high while one is in work.
//   Per item the controller steps through: send SEND then CLOSE; unknown
//   opcode NOP; ack MARK, one ADV step per slot the window base slides (up
//   to WINDOW_DEPTH), then FIN; timeout one RTX push per retransmitted
//   number (up to 32), one push when none is outstanding. The first result
//   is registered on CLOSE (send), NOP (unknown), RTX (timeout) or FIN (ack).
//   Results leave through a single output register; a held stall on the
//   output holds that register and the controller waits before the next push.
//   Registers: total_requests at 0x0, source_id at 0x4, to be written by the
//   user only while idle (unenforced). Reset clears window, ack ring, batch
//   counters, loads total_requests 1000000, source_id 0; no clearing pass.
`timescale 1ns / 1ps

module batched_window_retransmit_sender
  import bwrs_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  logic [TOTAL_W-1:0] total_q, total_d;
  logic [ID_W-1:0]    client_q, client_d;
  logic               wr_en;
  dp_cmd_t            cmd;
  dp_status_t         status;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    total_d  = total_q;
    client_d = client_q;
    if (wr_en) begin
      case (paddr[2])
        REG_TOTAL:  total_d  = pwdata[TOTAL_W-1:0];
        REG_CLIENT: client_d = pwdata[ID_W-1:0];
        default:    total_d  = total_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= TOTAL_RESET;
      client_q <= CLIENT_RESET;
    end else begin
      total_q  <= total_d;
      client_q <= client_d;
    end
  end

  always_comb begin
    case (paddr[2])
      REG_TOTAL:  prdata = {{(32 - TOTAL_W){1'b0}}, total_q};
      REG_CLIENT: prdata = {{(32 - ID_W){1'b0}}, client_q};
      default:    prdata = '0;
    endcase
  end

  bwrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_opcode_i (in_item_i.opcode),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  bwrs_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .total_i     (total_q),
    .client_i    (client_q),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

endmodule

### tb/sv/tb_batched_window_retransmit_sender.sv
// Self-checking bench for batched_window_retransmit_sender: a directed table and
// then random send/ack/timeout traffic, checked beat by beat against table rows or a sender model.
// Depends on bwrs_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_batched_window_retransmit_sender;
  import bwrs_pkg::*;

  localparam int unsigned WIN             = 32;
  localparam int unsigned DRAIN_CYCLES    = 48;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 90;
  localparam int unsigned PHASES          = 5;
  localparam logic [1:0]  OP_UNKNOWN      = 2'd3;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;

  // sender model state
  logic [31:0]    base_q;
  logic [31:0]    next_q;
  logic [WIN-1:0] acked;
  int unsigned    sent_cnt;
  int unsigned    batch_tx;
  int unsigned    batch_rx;
  bit             waiting;
  logic [23:0]    cfg_total;
  logic [15:0]    cfg_id;

  out_item_t   predicted_pkts[$];
  out_item_t   expected_pkts[$];
  dir_row_t    dir_rows[$];
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_hold = 0;
  bit          calm;

  batched_window_retransmit_sender u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void reset_model();
    base_q    = '0;
    next_q    = '0;
    acked     = '0;
    sent_cnt  = 0;
    batch_tx  = 0;
    batch_rx  = 0;
    waiting   = 1'b0;
    cfg_total = TOTAL_RESET;
    cfg_id    = CLIENT_RESET;
  endfunction

  function automatic bit can_emit();
    return batch_tx < WIN && sent_cnt < cfg_total && (next_q - base_q) < WIN;
  endfunction

  function automatic void open_batch();
    if (waiting && batch_rx >= batch_tx) begin
      waiting  = 1'b0;
      batch_tx = 0;
      batch_rx = 0;
    end
  endfunction

  function automatic void close_batch();
    if (!waiting && batch_tx > 0 && !can_emit()) begin
      waiting = 1'b1;
      open_batch();
    end
  endfunction

  function automatic void emit(kind_e k, logic [31:0] s);
    out_item_t p;
    p.kind      = k;
    p.seq       = (k == KIND_NONE) ? '0 : s;
    p.sender_id = (k == KIND_NONE) ? '0 : cfg_id;
    p.last      = 1'b0;
    p.all_sent  = 1'b0;
    predicted_pkts.push_back(p);
  endfunction

  function automatic void sender_predict(in_item_t it);
    logic [31:0] span;
    bit          done;
    predicted_pkts.delete();
    case (it.opcode)
      OP_SEND: begin
        if (!waiting && can_emit()) begin
          acked[next_q % WIN] = 1'b0;
          emit(KIND_NEW, next_q);
          next_q++;
          sent_cnt++;
          batch_tx++;
        end else begin
          emit(KIND_NONE, '0);
        end
        close_batch();
      end
      OP_ACK: begin
        span = next_q - base_q;
        if ((it.ack_seq - base_q) < span) acked[it.ack_seq % WIN] = 1'b1;
        for (int k = 0; k < WIN && base_q != next_q && acked[base_q % WIN]; k++) base_q++;
        if (batch_rx < BR_MAX) batch_rx++;
        open_batch();
        emit(KIND_NONE, '0);
      end
      OP_TIMEOUT: begin
        span = next_q - base_q;
        if (span > MAX_RUN) span = MAX_RUN;
        for (int unsigned i = 0; i < span; i++) emit(KIND_RETX, base_q + i);
        if (predicted_pkts.size() == 0) emit(KIND_NONE, '0);
      end
      default: emit(KIND_NONE, '0);
    endcase
    done = (sent_cnt >= cfg_total) && !waiting;
    foreach (predicted_pkts[i]) predicted_pkts[i].all_sent = done;
    predicted_pkts[predicted_pkts.size()-1].last = 1'b1;
  endfunction

  function automatic void add_row(logic [1:0] op, logic [31:0] ack, bit typed = 1'b0,
                                  kind_e k = KIND_NONE, logic [31:0] s = '0,
                                  logic [15:0] id = '0);
    dir_row_t r;
    r.item  = in_item_t'{opcode: op, ack_seq: ack};
    r.typed = typed;
    r.res   = out_item_t'{kind: k, seq: s, sender_id: id, last: 1'b1, all_sent: 1'b0};
    dir_rows.push_back(r);
  endfunction

  // Mostly sends and acks, the acks mostly in or near the window, so the base keeps moving.
  function automatic in_item_t rand_item();
    in_item_t    it;
    int unsigned pick;
    int unsigned sub;
    int unsigned span;
    it.ack_seq = $urandom;
    pick       = $urandom_range(99);
    sub        = $urandom_range(9);
    span       = next_q - base_q;
    if (pick < 45) begin
      it.opcode = OP_SEND;
    end else if (pick < 85) begin
      it.opcode = OP_ACK;
      if (sub < 7) it.ack_seq = base_q + $urandom_range(span);
      else if (sub < 9) it.ack_seq = base_q - $urandom_range(3, 1);
    end else if (pick < 96) begin
      it.opcode = OP_TIMEOUT;
    end else begin
      it.opcode = OP_UNKNOWN;
    end
    return it;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned pick;
    pick = $urandom_range(99);
    if (calm || pick < 60) return 0;
    if (pick < 90) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  // Returns at the clock edge after the access edge, with psel low.
  task automatic cfg_write(logic reg_idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (reg_idx == REG_TOTAL) cfg_total = val[23:0];
    else cfg_id = val[15:0];
  endtask

  // Called at a rising edge; returns at the edge the beat is taken (gap 0)
  // or after the gap, with valid low.
  task automatic send_beat(in_item_t it, bit typed, out_item_t typed_res);
    int unsigned gap;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sender_predict(it);
    if (typed) expected_pkts.push_back(typed_res);
    else foreach (predicted_pkts[i]) expected_pkts.push_back(predicted_pkts[i]);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (expected_pkts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [31:0] new_total;
    logic [31:0] new_id;
    out_item_t   unused_res;
    rst_ni       <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid_i   <= 1'b0;
    in_item_i    <= '0;
    calm         = 1'b0;
    unused_res   = '0;
    reset_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cfg_write(REG_TOTAL, 32'h00FF_FFFF);
    cfg_write(REG_CLIENT, 32'h0000_FFFF);

    add_row(OP_TIMEOUT, 32'h0000_0000, 1'b1);                 // nothing outstanding
    add_row(OP_UNKNOWN, 32'hFFFF_FFFF, 1'b1);
    add_row(OP_ACK, 32'hFFFF_FFFF, 1'b1);                     // empty window, still counted
    add_row(OP_SEND, 32'h0000_0000, 1'b1, KIND_NEW, 32'd0, 16'hFFFF);
    add_row(OP_SEND, 32'hFFFF_FFFF, 1'b1, KIND_NEW, 32'd1, 16'hFFFF);
    add_row(OP_SEND, 32'h0000_0000, 1'b1, KIND_NEW, 32'd2, 16'hFFFF);
    add_row(OP_TIMEOUT, 32'h0000_0000);
    add_row(OP_ACK, 32'd1);                                   // out of order, base holds
    add_row(OP_ACK, 32'd0);                                   // base slides past 0 and 1
    add_row(OP_ACK, 32'd1);                                   // duplicate below base
    add_row(OP_ACK, 32'd2);
    add_row(OP_TIMEOUT, 32'hFFFF_FFFF, 1'b1);
    add_row(OP_ACK, 32'h8000_0000);
    add_row(OP_UNKNOWN, 32'h5555_5555, 1'b1);
    add_row(OP_SEND, 32'hAAAA_AAAA);
    add_row(OP_SEND, 32'h0000_0000);
    add_row(OP_TIMEOUT, 32'h0000_0000);
    add_row(OP_ACK, 32'd4);
    add_row(OP_ACK, 32'd3);
    foreach (dir_rows[i]) send_beat(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    in_valid_i <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      calm = (ph == 2);
      case (ph)
        0: begin
          new_total = sent_cnt + 45;
          new_id    = $urandom;
        end
        1: begin
          new_total = '0;
          new_id    = '0;
        end
        2: begin
          new_total = sent_cnt + 1;
          new_id    = 32'h0000_FFFF;
        end
        3: begin
          new_total = sent_cnt + $urandom_range(200, 60);
          new_id    = $urandom;
        end
        default: begin
          new_total = 32'h00FF_FFFF;
          new_id    = $urandom;
        end
      endcase
      cfg_write(REG_TOTAL, new_total & 32'h00FF_FFFF);
      cfg_write(REG_CLIENT, new_id & 32'h0000_FFFF);
      repeat (ITEMS_PER_PHASE) send_beat(rand_item(), 1'b0, unused_res);
      in_valid_i <= 1'b0;
    end

    wait_drained();
    if (mismatch_cnt == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Output stall: mostly short stalls, sometimes long ones, with free stretches.
  always @(posedge clk_i) begin : stall_gen
    int unsigned pick;
    pick = $urandom_range(99);
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (calm || pick < 50) begin
      out_stall_i <= 1'b0;
      stall_hold  <= calm ? 0 : $urandom_range(20);
    end else if (pick < 92) begin
      out_stall_i <= 1'b1;
      stall_hold  <= $urandom_range(3);
    end else begin
      out_stall_i <= 1'b1;
      stall_hold  <= $urandom_range(40, 10);
    end
  end

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pkts.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: unexpected result beat %p", $time, out_item_o);
      end else begin
        want = expected_pkts.pop_front();
        if (out_item_o.kind !== want.kind) begin
          mismatch_cnt++;
          $display("%0t: kind expected %0d got %0d", $time, want.kind, out_item_o.kind);
        end
        if (out_item_o.seq !== want.seq) begin
          mismatch_cnt++;
          $display("%0t: seq expected %0h got %0h", $time, want.seq, out_item_o.seq);
        end
        if (out_item_o.sender_id !== want.sender_id) begin
          mismatch_cnt++;
          $display("%0t: sender_id expected %0h got %0h", $time, want.sender_id,
                   out_item_o.sender_id);
        end
        if (out_item_o.last !== want.last) begin
          mismatch_cnt++;
          $display("%0t: last expected %0b got %0b", $time, want.last, out_item_o.last);
        end
        if (out_item_o.all_sent !== want.all_sent) begin
          mismatch_cnt++;
          $display("%0t: all_sent expected %0b got %0b", $time, want.all_sent,
                   out_item_o.all_sent);
        end
      end
    end
  end

  // Watchdog: too long without a beat on either side ends the run.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
